// File: hw/rtl/rssi_bmp_pkg.sv
// Package for the RSSI sweep bin-max packer: constants, register indexes,
// configuration and byte-burst types, and the RSSI-to-byte mapping.
// No dependencies.
`default_nettype none

package rssi_bmp_pkg;

    // Message geometry
    localparam int MaxMsgBytes = 128;
    localparam int HdrBytes    = 11;
    localparam int BurstMax    = 12;       // header plus one bin on a one-sample sweep
    localparam int BurstCntW   = $clog2(BurstMax + 1);
    localparam int SumW        = 24;       // running sums wrap at this width
    localparam int BinCntW     = 7;

    // APB register map (index = paddr[4:2])
    localparam int PaddrW = 5;
    localparam logic [2:0] RegSampleCount = 3'd0;
    localparam logic [2:0] RegByteBudget  = 3'd1;
    localparam logic [2:0] RegTypeCode    = 3'd2;
    localparam logic [2:0] RegStartKhz    = 3'd3;
    localparam logic [2:0] RegEndKhz      = 3'd4;

    typedef struct packed {
        logic [15:0] sample_count;
        logic [7:0]  byte_budget;
        logic [7:0]  type_code;
        logic [31:0] start_khz;
        logic [31:0] end_khz;
    } t_cfg;

    // Bytes produced by one sample, head at index 0
    typedef struct packed {
        logic [BurstMax-1:0][7:0] bytes;
        logic [BurstMax-1:0]      lasts;
        logic [BurstCntW-1:0]     cnt;
    } t_burst;

    // 255 for non-negative samples, else sample+255 floored at 0
    function automatic logic [7:0] map_rssi(input logic signed [15:0] s);
        logic signed [16:0] sum;
        begin
            sum = 17'(s) + 17'sd255;
            if (!s[15]) begin
                map_rssi = 8'hFF;
            end else if (sum[16]) begin
                map_rssi = 8'h00;
            end else begin
                map_rssi = sum[7:0];
            end
        end
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/rssi_bmp_if.sv
// Valid/ready channel interfaces for the RSSI packer: sample input and
// message byte output. Depends on nothing.
`default_nettype none

interface rssi_bmp_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] rssi;

    modport source (output valid, output rssi, input ready);
    modport sink   (input valid, input rssi, output ready);
endinterface

interface rssi_bmp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/rssi_bmp_regs.sv
// APB configuration registers of the RSSI packer.
// Depends on rssi_bmp_pkg.
`default_nettype none

module rssi_bmp_regs (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [rssi_bmp_pkg::PaddrW-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    output rssi_bmp_pkg::t_cfg               o_cfg
);
    import rssi_bmp_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign o_cfg   = r_cfg;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sample_count <= 16'd1;
            r_cfg.byte_budget  <= 8'd128;
            r_cfg.type_code    <= 8'd0;
            r_cfg.start_khz    <= 32'd0;
            r_cfg.end_khz      <= 32'd0;
        end else if (wr_en) begin
            case (reg_idx)
                RegSampleCount: r_cfg.sample_count <= pwdata[15:0];
                RegByteBudget:  r_cfg.byte_budget  <= pwdata[7:0];
                RegTypeCode:    r_cfg.type_code    <= pwdata[7:0];
                RegStartKhz:    r_cfg.start_khz    <= pwdata;
                RegEndKhz:      r_cfg.end_khz      <= pwdata;
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        case (reg_idx)
            RegSampleCount: prdata = {16'd0, r_cfg.sample_count};
            RegByteBudget:  prdata = {24'd0, r_cfg.byte_budget};
            RegTypeCode:    prdata = {24'd0, r_cfg.type_code};
            RegStartKhz:    prdata = r_cfg.start_khz;
            RegEndKhz:      prdata = r_cfg.end_khz;
            default:        prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/rssi_bmp_pack.sv
// Sample input register, sweep state and the single-pass logic that turns
// one sample into its burst of message bytes. Depends on rssi_bmp_pkg.
`default_nettype none

module rssi_bmp_pack (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire rssi_bmp_pkg::t_cfg i_cfg,
    input  wire logic               i_valid,
    input  wire logic signed [15:0] i_rssi,
    output logic                    o_ready,
    input  wire logic               i_can_load,
    output logic                    o_load,
    output rssi_bmp_pkg::t_burst    o_burst
);
    import rssi_bmp_pkg::*;

    // Input register
    logic               r_in_vld;
    logic signed [15:0] r_in_rssi;

    // Sweep state
    logic [15:0]        r_idx;
    logic [7:0]         r_peak;
    logic [BinCntW-1:0] r_bins;
    logic [SumW-1:0]    r_sis;
    logic [SumW-1:0]    r_nb;

    logic [15:0]        n_idx;
    logic [7:0]         n_peak;
    logic [BinCntW-1:0] n_bins;
    logic [SumW-1:0]    n_sis;
    logic [SumW-1:0]    n_nb;

    logic [15:0]        cnt_eff;
    logic [7:0]         budget;
    logic [3:0]         hdr_len;
    logic [7:0]         rem_full;
    logic [6:0]         rem;
    logic               is_first;
    logic [7:0]         eff_peak;
    logic [BinCntW-1:0] eff_bins;
    logic [SumW-1:0]    eff_sis;
    logic [SumW-1:0]    eff_nb;
    logic               mid;
    logic               mid_emit;
    logic [BinCntW-1:0] bins1;
    logic [SumW-1:0]    nb1;
    logic [7:0]         mapped;
    logic [7:0]         peak2;
    logic               fin;
    logic               fin_emit;
    logic [3:0]         hlen;
    logic [7:0]         hdr [HdrBytes];

    assign o_ready = !r_in_vld || i_can_load;
    assign o_load  = r_in_vld && i_can_load;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_ready) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_rssi <= i_rssi;
        end
    end

    // Header bytes, little-endian fields
    always_comb begin
        hdr[0]  = i_cfg.type_code;
        hdr[1]  = i_cfg.sample_count[7:0];
        hdr[2]  = i_cfg.sample_count[15:8];
        hdr[3]  = i_cfg.start_khz[7:0];
        hdr[4]  = i_cfg.start_khz[15:8];
        hdr[5]  = i_cfg.start_khz[23:16];
        hdr[6]  = i_cfg.start_khz[31:24];
        hdr[7]  = i_cfg.end_khz[7:0];
        hdr[8]  = i_cfg.end_khz[15:8];
        hdr[9]  = i_cfg.end_khz[23:16];
        hdr[10] = i_cfg.end_khz[31:24];
    end

    // Per-sample step: header, bin boundary, pooling, end of sweep
    always_comb begin
        cnt_eff = (i_cfg.sample_count == 16'd0) ? 16'd1 : i_cfg.sample_count;
        budget  = (i_cfg.byte_budget > 8'(MaxMsgBytes)) ? 8'(MaxMsgBytes)
                                                         : i_cfg.byte_budget;
        hdr_len = (budget < 8'(HdrBytes)) ? budget[3:0] : 4'(HdrBytes);
        rem_full = budget - {4'd0, hdr_len};
        rem      = ({8'd0, rem_full} > cnt_eff) ? cnt_eff[6:0] : rem_full[6:0];

        is_first = (r_idx == 16'd0);
        eff_peak = is_first ? 8'd0 : r_peak;
        eff_bins = is_first ? '0 : r_bins;
        eff_sis  = is_first ? '0 : r_sis;
        eff_nb   = is_first ? {8'd0, cnt_eff} : r_nb;

        // Close the current bin at a boundary
        mid      = (eff_sis >= eff_nb);
        mid_emit = mid && (({4'd0, hdr_len} + {1'b0, eff_bins}) < budget);
        bins1    = eff_bins + BinCntW'(mid_emit);
        nb1      = mid_emit ? (eff_nb + {8'd0, cnt_eff}) : eff_nb;

        // Max pooling of the mapped sample
        mapped = map_rssi(r_in_rssi);
        peak2  = mid ? mapped : ((mapped > eff_peak) ? mapped : eff_peak);

        fin      = (({1'b0, r_idx} + 17'd1) >= {1'b0, cnt_eff});
        fin_emit = fin && (({4'd0, hdr_len} + {1'b0, bins1}) < budget);

        // Next state
        if (fin) begin
            n_idx  = 16'd0;
            n_peak = 8'd0;
            n_bins = '0;
            n_sis  = '0;
            n_nb   = '0;
        end else begin
            n_idx  = r_idx + 16'd1;
            n_peak = peak2;
            n_bins = bins1;
            n_sis  = eff_sis + {17'd0, rem};
            n_nb   = nb1;
        end

        // Burst assembly: header, then the closed bin, then the final bin
        hlen = is_first ? hdr_len : 4'd0;
        for (int p = 0; p < BurstMax; p++) begin
            if (4'(p) < hlen) begin
                o_burst.bytes[p] = hdr[p % HdrBytes];
                o_burst.lasts[p] = (8'(p + 1) == budget);
            end else if (4'(p) == hlen && mid_emit) begin
                o_burst.bytes[p] = eff_peak;
                o_burst.lasts[p] = 1'b0;
            end else begin
                o_burst.bytes[p] = peak2;
                o_burst.lasts[p] = 1'b1;
            end
        end
        o_burst.cnt = hlen + BurstCntW'(mid_emit) + BurstCntW'(fin_emit);
    end

    // Sweep state update on each loaded sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= 16'd0;
            r_peak <= 8'd0;
            r_bins <= '0;
            r_sis  <= '0;
            r_nb   <= '0;
        end else if (o_load) begin
            r_idx  <= n_idx;
            r_peak <= n_peak;
            r_bins <= n_bins;
            r_sis  <= n_sis;
            r_nb   <= n_nb;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/rssi_bmp_serial.sv
// Result register for one sample's byte burst, shifted out one byte per
// accepted output request. Depends on rssi_bmp_pkg.
`default_nettype none

module rssi_bmp_serial (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_load,
    input  wire rssi_bmp_pkg::t_burst i_burst,
    output logic                      o_can_load,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [7:0]                o_byte,
    output logic                      o_last
);
    import rssi_bmp_pkg::*;

    logic [BurstMax-1:0][7:0] r_bytes;
    logic [BurstMax-1:0]      r_lasts;
    logic [BurstCntW-1:0]     r_cnt;
    logic                     take;

    assign o_valid    = (r_cnt != '0);
    assign take       = o_valid && i_ready;
    assign o_can_load = (r_cnt == '0) || ((r_cnt == BurstCntW'(1)) && i_ready);
    assign o_byte     = r_bytes[0];
    assign o_last     = r_lasts[0];

    // Byte count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_burst.cnt;
        end else if (take) begin
            r_cnt <= r_cnt - BurstCntW'(1);
        end
    end

    // Burst shift register
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes <= i_burst.bytes;
            r_lasts <= i_burst.lasts;
        end else if (take) begin
            for (int p = 0; p < BurstMax - 1; p++) begin
                r_bytes[p] <= r_bytes[p+1];
                r_lasts[p] <= r_lasts[p+1];
            end
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/rssi_sweep_bin_max_packer_unit.sv
// RSSI sweep bin-max packer: top level. An accepted sample waits in the input
// register until the byte shift register loads its burst, whose first byte is
// then valid. Throughput: one sample per cycle while each gives at most one
// byte and the receiver is ready; a sample that gives more bytes holds the
// byte shift register until all are taken (up to 12 on the first sample of a
// sweep). Reset (synchronous, active low) clears the sweep state and restores
// the register defaults. Depends on rssi_bmp_pkg, rssi_bmp_if, regs, pack, serial.
`default_nettype none

module rssi_sweep_bin_max_packer_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    rssi_bmp_in_if.sink                          i_in,
    rssi_bmp_out_if.source                       o_out,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [rssi_bmp_pkg::PaddrW-1:0] paddr,
    input  wire logic [31:0]                     pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);
    import rssi_bmp_pkg::*;

    t_cfg   cfg;
    t_burst burst;
    logic   load;
    logic   can_load;

    rssi_bmp_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    rssi_bmp_pack u_pack (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_valid    (i_in.valid),
        .i_rssi     (i_in.rssi),
        .o_ready    (i_in.ready),
        .i_can_load (can_load),
        .o_load     (load),
        .o_burst    (burst)
    );

    rssi_bmp_serial u_serial (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_burst    (burst),
        .o_can_load (can_load),
        .o_valid    (o_out.valid),
        .i_ready    (o_out.ready),
        .o_byte     (o_out.out_byte),
        .o_last     (o_out.last)
    );

endmodule

`default_nettype wire

// File: dv/rssi_bmp_checker.sv
// Scoreboard for the RSSI sweep packer: watches the sample, byte and APB
// channels, predicts each message byte and compares it with what comes out.
// Depends on rssi_bmp_pkg and rssi_bmp_if.
`default_nettype none

module rssi_bmp_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    rssi_bmp_in_if                               i_in,
    rssi_bmp_out_if                              i_out,
    input  wire logic                            i_psel,
    input  wire logic                            i_penable,
    input  wire logic                            i_pwrite,
    input  wire logic [rssi_bmp_pkg::PaddrW-1:0] i_paddr,
    input  wire logic [31:0]                     i_pwdata,
    input  wire logic                            i_pready,
    output int                                   o_err_cnt,
    output int                                   o_pending
);
    import rssi_bmp_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_msg_byte;

    t_msg_byte   bytes_due [$];

    // Register shadow and sweep state, both as seen by the block
    t_cfg        cfg;
    logic [15:0] sample_idx;
    logic [7:0]  bin_peak;
    logic [6:0]  bins_sent;
    logic [23:0] idx_sum;
    logic [23:0] boundary;

    task automatic note_fail(input string msg);
        o_err_cnt++;
        if (o_err_cnt <= 10) begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
    endtask

    task automatic push_byte(input logic [7:0] data, input logic last);
        t_msg_byte mb;
        mb.data = data;
        mb.last = last;
        bytes_due.push_back(mb);
    endtask

    task automatic clear_sweep();
        sample_idx = '0;
        bin_peak   = '0;
        bins_sent  = '0;
        idx_sum    = '0;
        boundary   = '0;
    endtask

    // Bytes caused by one accepted sample request
    task automatic pack_sample(input logic signed [15:0] rssi);
        int         budget;
        int         count;
        int         hdr_len;
        int         room;
        int         level;
        int         k;
        logic [7:0] hdr [HdrBytes];
        logic [7:0] level_byte;

        budget  = (int'(cfg.byte_budget) > MaxMsgBytes) ? MaxMsgBytes : int'(cfg.byte_budget);
        count   = (cfg.sample_count == 16'd0) ? 1 : int'(cfg.sample_count);
        hdr_len = (budget < HdrBytes) ? budget : HdrBytes;
        room    = budget - hdr_len;
        if (room > count) begin
            room = count;
        end

        // First sample of a sweep: header (cut at the budget), fresh bins
        if (sample_idx == 16'd0) begin
            hdr[0] = cfg.type_code;
            hdr[1] = cfg.sample_count[7:0];
            hdr[2] = cfg.sample_count[15:8];
            for (k = 0; k < 4; k++) begin
                hdr[3 + k] = cfg.start_khz[8*k +: 8];
                hdr[7 + k] = cfg.end_khz[8*k +: 8];
            end
            for (k = 0; k < hdr_len; k++) begin
                push_byte(hdr[k], k + 1 == budget);
            end
            bin_peak  = '0;
            bins_sent = '0;
            idx_sum   = '0;
            boundary  = 24'(count);
        end

        // Close the open bin once i*bins reaches the next multiple of count
        if (idx_sum >= boundary) begin
            if (hdr_len + int'(bins_sent) < budget) begin
                push_byte(bin_peak, 1'b0);
                bins_sent++;
                boundary = boundary + 24'(count);
            end
            bin_peak = '0;
        end

        // Byte level: 255 from 0 dBm up, floored at 0 below -255
        level = int'(rssi) + 255;
        if (rssi >= 0) begin
            level_byte = 8'hFF;
        end else if (level < 0) begin
            level_byte = 8'h00;
        end else begin
            level_byte = 8'(level);
        end
        if (level_byte > bin_peak) begin
            bin_peak = level_byte;
        end
        idx_sum = idx_sum + 24'(room);

        // Last sample: flush the final bin, sweep starts over
        if (int'(sample_idx) + 1 >= count) begin
            if (hdr_len + int'(bins_sent) < budget) begin
                push_byte(bin_peak, 1'b1);
            end
            clear_sweep();
        end else begin
            sample_idx++;
        end
    endtask

    always @(posedge i_clk) begin
        t_msg_byte want;
        if (!i_rst_n) begin
            cfg.sample_count = 16'd1;
            cfg.byte_budget  = 8'd128;
            cfg.type_code    = '0;
            cfg.start_khz    = '0;
            cfg.end_khz      = '0;
            clear_sweep();
            bytes_due.delete();
        end else begin
            // Register writes complete at the access cycle
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[4:2])
                    RegSampleCount: cfg.sample_count = i_pwdata[15:0];
                    RegByteBudget:  cfg.byte_budget  = i_pwdata[7:0];
                    RegTypeCode:    cfg.type_code    = i_pwdata[7:0];
                    RegStartKhz:    cfg.start_khz    = i_pwdata;
                    RegEndKhz:      cfg.end_khz      = i_pwdata;
                    default: ;
                endcase
            end

            if (i_in.valid && i_in.ready) begin
                pack_sample(i_in.rssi);
            end

            // Compare each delivered byte with the oldest one due
            if (i_out.valid && i_out.ready) begin
                if (bytes_due.size() == 0) begin
                    note_fail($sformatf("byte 0x%02h last %0b with none expected",
                                        i_out.out_byte, i_out.last));
                end else begin
                    want = bytes_due.pop_front();
                    if (i_out.out_byte !== want.data) begin
                        note_fail($sformatf("out_byte expected 0x%02h got 0x%02h",
                                            want.data, i_out.out_byte));
                    end
                    if (i_out.last !== want.last) begin
                        note_fail($sformatf("last expected %0b got %0b (byte 0x%02h)",
                                            want.last, i_out.last, want.data));
                    end
                end
            end
        end
        o_pending = bytes_due.size();
    end

endmodule

`default_nettype wire

// File: dv/tb.sv
// Top of the RSSI sweep packer bench: clock, reset, APB register writes,
// sample stimulus with idling and back-pressure, watchdog and verdict.
// Depends on rssi_bmp_pkg, rssi_bmp_if, the packer RTL and rssi_bmp_checker.
`default_nettype none

module tb;
    import rssi_bmp_pkg::*;

    localparam int SettleCycles  = 8;
    localparam int StallCycles   = 150;
    localparam int WatchdogLimit = 2000;
    localparam int RandomItems   = 460;
    localparam int MaxItems      = 500;
    localparam int CalmFrom      = 380;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [PaddrW-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    int                err_cnt;
    int                pending;
    int                n_sent = 0;
    int                watch_cnt;
    logic              idle_on = 1'b1;
    logic              stall_req = 1'b0;

    rssi_bmp_in_if  in_ch ();
    rssi_bmp_out_if out_ch ();

    rssi_sweep_bin_max_packer_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    rssi_bmp_checker chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_ch),
        .i_out     (out_ch),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .i_pready  (pready),
        .o_err_cnt (err_cnt),
        .o_pending (pending)
    );

    always #5 i_clk = ~i_clk;

    // Byte receiver: random stalls, one long hold-off on request
    initial begin
        int n;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_req) begin
                out_ch.ready <= 1'b0;
                repeat (StallCycles - 1) @(negedge i_clk);
                stall_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 8);
                out_ch.ready <= 1'b0;
                repeat (n - 1) @(negedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: cycles with no request accepted on any port
    initial begin
        watch_cnt = 0;
        while (watch_cnt < WatchdogLimit) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                (psel && penable && pwrite && pready)) begin
                watch_cnt = 0;
            end else begin
                watch_cnt++;
            end
        end
        $display("status: fail");
        $finish;
    end

    // Offer one sample; returns at the falling edge after acceptance, valid still high
    task automatic send_sample(input logic [15:0] rssi);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.rssi  <= rssi;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
        n_sent++;
    endtask

    // Stop offering and wait until every predicted byte has come out
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SettleCycles) @(negedge i_clk);
    endtask

    // APB write: setup cycle, access cycle, then the bus goes idle before return
    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic [15:0] pick_rssi();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom());
            1:       return 16'(-int'($urandom_range(0, 300)));
            2:       return 16'($urandom_range(0, 40));
            default: return 16'(-int'($urandom_range(256, 32768)));
        endcase
    endfunction

    initial begin
        int count;
        int budget;
        int n_items;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        in_ch.valid = 1'b0;
        in_ch.rssi  = '0;
        i_rst_n     = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset defaults: one-sample sweeps, header plus one bin each
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        wait_drained();

        // Smallest useful budget, mapping corners: 0, -1, -255, -256, -100
        reg_write(RegTypeCode, 32'hA5);
        reg_write(RegStartKhz, 32'hFFFF_FFFF);
        reg_write(RegEndKhz, 32'h8000_0001);
        reg_write(RegSampleCount, 32'd5);
        reg_write(RegByteBudget, 32'd12);
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        send_sample(16'hFF01);
        send_sample(16'hFF00);
        send_sample(16'hFF9C);
        wait_drained();

        // Budget beyond the buffer size
        reg_write(RegByteBudget, 32'd200);
        reg_write(RegSampleCount, 32'd3);
        send_sample(16'hFF02);
        send_sample(16'hFFF6);
        send_sample(16'h0005);
        wait_drained();

        // Budget inside the header: header cut short, no bins
        reg_write(RegByteBudget, 32'd5);
        reg_write(RegSampleCount, 32'd2);
        send_sample(16'h0001);
        send_sample(16'h0002);
        wait_drained();
        reg_write(RegByteBudget, 32'd11);
        reg_write(RegSampleCount, 32'd1);
        send_sample(16'hFFEC);
        wait_drained();

        // Zero sample count, then zero budget (no output at all)
        reg_write(RegSampleCount, 32'd0);
        reg_write(RegByteBudget, 32'd20);
        send_sample(16'hFFFD);
        wait_drained();
        reg_write(RegByteBudget, 32'd0);
        send_sample(16'h0007);
        wait_drained();

        // Longest sweep, cut short by shrinking count and budget mid-sweep
        reg_write(RegTypeCode, 32'h3C);
        reg_write(RegStartKhz, 32'h1234_5678);
        reg_write(RegEndKhz, 32'h9ABC_DEF0);
        reg_write(RegSampleCount, 32'd65535);
        reg_write(RegByteBudget, 32'd128);
        repeat (6) send_sample(pick_rssi());
        wait_drained();
        reg_write(RegByteBudget, 32'd13);
        reg_write(RegSampleCount, 32'd8);
        repeat (2) send_sample(pick_rssi());
        wait_drained();

        // Back-pressure: full header bursts against a stalled receiver
        reg_write(RegSampleCount, 32'd1);
        reg_write(RegByteBudget, 32'd128);
        stall_req = 1'b1;
        repeat (20) send_sample(pick_rssi());
        wait_drained();

        // Random sweeps; some phases leave a sweep open across a config change
        while (n_sent < RandomItems) begin
            if (n_sent >= CalmFrom) begin
                idle_on = 1'b0;
            end
            case ($urandom_range(0, 19))
                0:       count = 0;
                1, 2:    count = $urandom_range(41, 300);
                default: count = $urandom_range(1, 40);
            endcase
            case ($urandom_range(0, 6))
                0:       budget = $urandom_range(0, 11);
                1:       budget = $urandom_range(129, 255);
                default: budget = $urandom_range(12, 128);
            endcase
            reg_write(RegSampleCount, count);
            reg_write(RegByteBudget, budget);
            if ($urandom_range(0, 2) == 0) begin
                reg_write(RegTypeCode, $urandom_range(0, 255));
            end
            if ($urandom_range(0, 2) == 0) begin
                reg_write(RegStartKhz, $urandom());
            end
            if ($urandom_range(0, 2) == 0) begin
                reg_write(RegEndKhz, $urandom());
            end
            if (count > 40) begin
                n_items = count;
            end else begin
                n_items = $urandom_range(1, 3) * ((count == 0) ? 1 : count);
            end
            if ($urandom_range(0, 5) == 0) begin
                n_items += $urandom_range(1, 5);
            end
            // Keep the total near the planned item count
            if (n_sent + n_items > MaxItems) begin
                n_items = MaxItems - n_sent;
            end
            repeat (n_items) send_sample(pick_rssi());
            wait_drained();
        end

        if (err_cnt == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
